FILE: rtl/stlbs_pkg.sv
// Shared types and constants for the sorted text line search block.
package stlbs_pkg;
  localparam int STORE_BYTES = 65536;
  localparam int ADDR_W = $clog2(STORE_BYTES);
  localparam int PTR_W = ADDR_W + 1;
  localparam int NUMBER_SCAN_BYTES = 60;
  localparam int SCAN_W = $clog2(NUMBER_SCAN_BYTES + 1);
  localparam logic [31:0] HEADER_LIMIT = 32'd9340031;
  localparam logic [31:0] NUM_MAX = 32'h7FFF_FFFF;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_REWIND = 2'd2;

  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  load_byte;
    logic [23:0] search_id;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic       char_valid;
    logic [7:0] text_char;
    logic       last;
  } out_item_t;

  // Read request / write request to the byte store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;
endpackage

FILE: rtl/sorted_text_line_binary_search.sv
// Top level of the sorted text line search block.
// Loads a text image byte by byte (mode 0), rewinds the write pointer (mode 2) and looks
// up a record by leading decimal ID (mode 1). The image's first line holds the record
// region length; records follow sorted by ID. A query walks the byte store through its
// single read port one byte per cycle: the header number, newline scans and per-probe
// number parses over about log2(records) probes, then emits the matched line one item
// per character (at most max_line_size-1, 0 counting as 1, and at most 63), one found
// item without a character if none is shown, or one not-found item. Each scan issues
// its first read before it consumes a byte. Emission waits on any output stall, and a
// query holds off new input until its last item is taken; loads and rewinds do not.
// The user must write configuration only while idle; the block itself does not enforce it.
module sorted_text_line_binary_search (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  stlbs_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output stlbs_pkg::out_item_t  out_data,
  input  logic                  cfg_we,
  input  logic [6:0]            cfg_data
);
  import stlbs_pkg::*;

  logic [6:0] max_line_size_r;
  mem_req_t   mreq;
  logic [7:0] rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) max_line_size_r <= 7'd64;
    else if (cfg_we) max_line_size_r <= cfg_data;
  end

  stlbs_store u_store (.clk(clk), .req(mreq), .rdata(rdata));

  stlbs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .lim_cfg(max_line_size_r), .mreq(mreq), .rdata(rdata)
  );
endmodule

FILE: rtl/stlbs_store.sv
// Byte store: one write port, one registered read port.
module stlbs_store (
  input  logic                 clk,
  input  stlbs_pkg::mem_req_t  req,
  output logic [7:0]           rdata
);
  import stlbs_pkg::*;
  logic [7:0] mem [STORE_BYTES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end
endmodule

FILE: rtl/stlbs_ctrl.sv
// Sequencer: loads, header parse, line-aligned binary search and line emission.
module stlbs_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  stlbs_pkg::in_item_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output stlbs_pkg::out_item_t  out_data,
  input  logic [6:0]            lim_cfg,
  output stlbs_pkg::mem_req_t   mreq,
  input  logic [7:0]            rdata
);
  import stlbs_pkg::*;

  // States
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NUM    = 4'd1;  // parse leading number at pos_r
  localparam logic [3:0] S_NL     = 4'd2;  // scan for newline from pos_r
  localparam logic [3:0] S_EMIT   = 4'd3;  // read char
  localparam logic [3:0] S_OUT    = 4'd4;  // waiting for out handshake, or peeking the next byte
  localparam logic [3:0] S_DECIDE = 4'd5;  // compare id, update bounds

  // What the number / newline result feeds
  localparam logic [2:0] J_HDR    = 3'd0;  // header number parsed
  localparam logic [2:0] J_BEGIN  = 3'd1;  // next_line(0) -> begin
  localparam logic [2:0] J_MID    = 3'd2;  // next_line(mid)
  localparam logic [2:0] J_FB     = 3'd3;  // next_line(begin) fallback
  localparam logic [2:0] J_PROBE  = 3'd4;  // probe id parsed
  localparam logic [2:0] J_ADV    = 3'd5;  // next_line(test) -> begin

  logic [3:0]        st_r;
  logic [2:0]        job_r;
  logic [PTR_W-1:0]  wp_r;
  logic [PTR_W-1:0]  ptr_r;       // unused
  logic [PTR_W-1:0]  pos_r;       // current address
  logic              pend_r;      // read of pos_r already issued
  logic [SCAN_W-1:0] cnt_r;
  logic [1:0]        ph_r;        // 0 space/sign, 2 digits, 3 bounds set
  logic              neg_r;
  logic [31:0]       mag_r;
  logic [PTR_W-1:0]  beg_r, end_r, test_r;
  logic [23:0]       sid_r;
  logic [5:0]        n_r, lim_r;
  out_item_t         ob_r;
  logic              ov_r;

  logic [7:0] c;
  assign c = pos_r[ADDR_W] ? CH_NUL : rdata;

  logic in_acc;
  assign in_acc = in_valid && in_ready;
  assign in_ready = (st_r == S_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_data = ob_r;

  // read address: one ahead when consuming
  logic [PTR_W-1:0] rpos;
  always_comb begin
    mreq.we = in_acc && (in_data.mode == MODE_LOAD) && !wp_r[ADDR_W];
    mreq.waddr = wp_r[ADDR_W-1:0];
    mreq.wdata = in_data.load_byte;
    rpos = pos_r;
    if (pend_r && st_r != S_IDLE && st_r != S_OUT && st_r != S_DECIDE) rpos = pos_r + 1'b1;
    mreq.raddr = rpos[ADDR_W-1:0];
  end

  // atol value from magnitude
  logic signed [33:0] numval;
  always_comb begin
    if (neg_r) numval = -$signed({2'b00, mag_r});
    else numval = (mag_r > NUM_MAX) ? $signed({2'b00, NUM_MAX}) : $signed({2'b00, mag_r});
  end

  logic [35:0] mag10;
  assign mag10 = {4'd0, mag_r} * 36'd10 + {28'd0, c - CH_0};

  logic ws, dig;
  assign ws = (c == CH_SP) || (c >= 8'd9 && c <= 8'd13);
  assign dig = (c >= CH_0) && (c <= CH_9);

  logic [PTR_W:0] midsum;
  assign midsum = {1'b0, beg_r} + {1'b0, end_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      wp_r <= '0;
      ov_r <= 1'b0;
      pend_r <= 1'b0;
      job_r <= J_HDR;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          if (in_acc) begin
            case (in_data.mode)
              MODE_LOAD: if (!wp_r[ADDR_W]) wp_r <= wp_r + 1'b1;
              MODE_REWIND: wp_r <= '0;
              MODE_QUERY: begin
                sid_r <= in_data.search_id;
                lim_r <= (lim_cfg == 7'd0) ? 6'd0 :
                         (lim_cfg > 7'd64) ? 6'd63 : 6'(lim_cfg - 7'd1);
                job_r <= J_HDR;
                pos_r <= '0;
                cnt_r <= '0; ph_r <= 2'd0; neg_r <= 1'b0; mag_r <= '0;
                pend_r <= 1'b0;
                st_r <= S_NUM;
              end
              default: ;
            endcase
          end
        end
        S_NUM: begin
          // on entry the read of pos_r is issued; after that pos_r data is in c
          if (!pend_r) begin
            pend_r <= 1'b1;
          end else if (cnt_r == SCAN_W'(NUMBER_SCAN_BYTES)) begin
            st_r <= S_DECIDE; pend_r <= 1'b0;
          end else if (ph_r == 2'd0 && ws) begin
            cnt_r <= cnt_r + 1'b1; pos_r <= pos_r + 1'b1;
          end else if (ph_r == 2'd0 && (c == CH_PLUS || c == CH_MINUS)) begin
            neg_r <= (c == CH_MINUS); ph_r <= 2'd2;
            cnt_r <= cnt_r + 1'b1; pos_r <= pos_r + 1'b1;
          end else if (dig) begin
            ph_r <= 2'd2;
            mag_r <= (mag10 > 36'h8000_0000) ? 32'h8000_0000 : mag10[31:0];
            cnt_r <= cnt_r + 1'b1; pos_r <= pos_r + 1'b1;
          end else begin
            st_r <= S_DECIDE; pend_r <= 1'b0;
          end
        end
        S_NL: begin
          if (!pend_r) begin
            pend_r <= 1'b1;
          end else if (pos_r[ADDR_W]) begin
            test_r <= PTR_W'(STORE_BYTES); st_r <= S_DECIDE; pend_r <= 1'b0;
          end else if (c == CH_LF) begin
            test_r <= pos_r + 1'b1; st_r <= S_DECIDE; pend_r <= 1'b0;
          end else pos_r <= pos_r + 1'b1;
        end
        S_DECIDE: begin
          case (job_r)
            J_HDR: begin
              if (numval <= 0 || numval > $signed({2'b00, HEADER_LIMIT})) begin
                ob_r <= '{1'b0, 1'b0, CH_NUL, 1'b1}; ov_r <= 1'b1; st_r <= S_OUT;
              end else begin
                mag_r <= numval[31:0];
                job_r <= J_BEGIN; pos_r <= '0; pend_r <= 1'b0; st_r <= S_NL;
              end
            end
            J_BEGIN: begin
              if ({16'd0, test_r} + {1'b0, mag_r} > 33'(STORE_BYTES)) begin
                ob_r <= '{1'b0, 1'b0, CH_NUL, 1'b1}; ov_r <= 1'b1; st_r <= S_OUT;
              end else begin
                beg_r <= test_r; end_r <= PTR_W'(test_r + mag_r[PTR_W-1:0]);
                job_r <= J_ADV; // reuse path: loop head
                st_r <= S_DECIDE;
                test_r <= test_r;
                ph_r <= 2'd3;
              end
            end
            J_ADV: begin
              // loop head; ph_r==3 means bounds already set
              if (ph_r != 2'd3) beg_r <= test_r;
              ph_r <= 2'd0;
              if ((ph_r == 2'd3 ? beg_r : test_r) < end_r) begin
                pos_r <= (ph_r == 2'd3) ? PTR_W'(midsum >> 1)
                       : PTR_W'(({1'b0, test_r} + {1'b0, end_r}) >> 1);
                job_r <= J_MID; pend_r <= 1'b0; st_r <= S_NL;
              end else begin
                ob_r <= '{1'b0, 1'b0, CH_NUL, 1'b1}; ov_r <= 1'b1; st_r <= S_OUT;
              end
            end
            J_MID: begin
              if (test_r >= end_r) begin
                pos_r <= beg_r; job_r <= J_FB; pend_r <= 1'b0; st_r <= S_NL;
              end else begin
                pos_r <= test_r; job_r <= J_PROBE;
                cnt_r <= '0; ph_r <= 2'd0; neg_r <= 1'b0; mag_r <= '0;
                pend_r <= 1'b0; st_r <= S_NUM;
              end
            end
            J_FB: begin
              pos_r <= (test_r >= end_r) ? beg_r : test_r;
              if (test_r >= end_r) test_r <= beg_r;
              job_r <= J_PROBE;
              cnt_r <= '0; ph_r <= 2'd0; neg_r <= 1'b0; mag_r <= '0;
              pend_r <= 1'b0; st_r <= S_NUM;
            end
            default: begin // J_PROBE
              if (numval == $signed({10'd0, sid_r})) begin
                pos_r <= test_r; n_r <= '0; pend_r <= 1'b0; st_r <= S_EMIT;
              end else if ($signed({10'd0, sid_r}) < numval) begin
                end_r <= test_r; ph_r <= 2'd3; job_r <= J_ADV; st_r <= S_DECIDE;
              end else begin
                pos_r <= test_r; job_r <= J_ADV; ph_r <= 2'd0;
                pend_r <= 1'b0; st_r <= S_NL;
              end
            end
          endcase
        end
        S_EMIT: begin
          if (!pend_r) begin
            pend_r <= 1'b1;
          end else begin
            pend_r <= 1'b0;
            if (n_r == lim_r || c == CH_NUL || c == CH_LF) begin
              if (n_r == 6'd0) begin
                ob_r <= '{1'b1, 1'b0, CH_NUL, 1'b1}; ov_r <= 1'b1;
              end
              st_r <= S_OUT; job_r <= J_HDR;
            end else begin
              // hold char; decide last after peeking next
              ob_r <= '{1'b1, 1'b1, c, 1'b0};
              n_r <= n_r + 1'b1; pos_r <= pos_r + 1'b1;
              st_r <= S_OUT; job_r <= J_PROBE;
            end
          end
        end
        default: begin // S_OUT
          if (job_r == J_PROBE) begin
            // char buffered, not yet shown: peek following byte
            if (!pend_r) begin
              pend_r <= 1'b1;
            end else begin
              ob_r.last <= (n_r == lim_r || c == CH_NUL || c == CH_LF);
              ov_r <= 1'b1; job_r <= J_BEGIN; pend_r <= 1'b0;
            end
          end else if (job_r == J_BEGIN) begin
            if (ov_r && out_ready) begin
              if (ob_r.last) begin st_r <= S_IDLE; job_r <= J_HDR; end
              else begin pend_r <= 1'b1; st_r <= S_EMIT; end
            end
          end else if (!ov_r || out_ready) begin
            st_r <= S_IDLE;
          end
        end
      endcase
    end
  end
endmodule

FILE: sim/sorted_text_line_binary_search_tb.sv
// Testbench for the sorted text line search block: loads text images and checks lookups.
module sorted_text_line_binary_search_tb;
  import stlbs_pkg::*;

  localparam int WATCHDOG_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [6:0] cfg_data = '0;

  sorted_text_line_binary_search uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block's state
  logic [7:0] shadow_mem [0:STORE_BYTES-1];
  int unsigned shadow_wptr;
  int unsigned line_cap_reg;

  out_item_t lookup_q[$];   // results still owed by the block
  logic [7:0] rec_bytes[$]; // record region of the image being built

  int errors = 0;
  int queries_sent = 0;
  int hits_seen = 0;
  int results_seen = 0;
  bit calm = 1'b0;          // when set, neither side idles
  int quiet_cycles = 0;

  task automatic report(string what, out_item_t got, out_item_t want);
    errors++;
    $display("MISMATCH %s: got f=%0d v=%0d c=%02h l=%0d want f=%0d v=%0d c=%02h l=%0d", what,
             got.found, got.char_valid, got.text_char, got.last,
             want.found, want.char_valid, want.text_char, want.last);
  endtask

  // ---------------- prediction ----------------
  function automatic logic [7:0] mem_at(longint a);
    return (a < STORE_BYTES) ? shadow_mem[a] : CH_NUL;
  endfunction

  // Position just after the next LF at or beyond p; store end if none.
  function automatic longint line_after(longint p);
    for (longint a = p; a < STORE_BYTES; a++)
      if (shadow_mem[a] == CH_LF) return a + 1;
    return STORE_BYTES;
  endfunction

  // atol-style leading number, bounded scan, saturating magnitude.
  function automatic longint leading_id(longint p);
    int i;
    bit neg;
    longint mag;
    logic [7:0] c;
    i = 0;
    neg = 1'b0;
    mag = 0;
    while (i < NUMBER_SCAN_BYTES) begin
      c = mem_at(p + i);
      if (c == CH_SP || (c >= 8'd9 && c <= 8'd13)) i++;
      else break;
    end
    if (i < NUMBER_SCAN_BYTES) begin
      c = mem_at(p + i);
      if (c == CH_PLUS || c == CH_MINUS) begin
        neg = (c == CH_MINUS);
        i++;
      end
    end
    while (i < NUMBER_SCAN_BYTES) begin
      c = mem_at(p + i);
      if (c < CH_0 || c > CH_9) break;
      mag = mag * 10 + longint'(c - CH_0);
      if (mag > longint'(NUM_MAX) + 1) mag = longint'(NUM_MAX) + 1;
      i++;
    end
    if (neg) return -mag;
    return (mag > longint'(NUM_MAX)) ? longint'(NUM_MAX) : mag;
  endfunction

  function automatic void push_result(bit f, bit v, logic [7:0] c, bit l);
    out_item_t r;
    r.found = f;
    r.char_valid = v;
    r.text_char = c;
    r.last = l;
    lookup_q.push_back(r);
  endfunction

  function automatic void predict_lookup(longint want);
    longint hdr, lo, hi, probe, id;
    int cap, n;
    logic [7:0] c;
    hdr = leading_id(0);
    if (hdr <= 0 || hdr > longint'(HEADER_LIMIT)) begin
      push_result(0, 0, CH_NUL, 1);
      return;
    end
    lo = line_after(0);
    hi = lo + hdr;
    if (hi > STORE_BYTES) begin
      push_result(0, 0, CH_NUL, 1);
      return;
    end
    while (lo < hi) begin
      probe = line_after(lo + (hi - lo) / 2);
      if (probe >= hi) probe = line_after(lo);
      if (probe >= hi) probe = lo;
      id = leading_id(probe);
      if (id == want) begin
        cap = (line_cap_reg < 1) ? 1 : (line_cap_reg > 64) ? 64 : line_cap_reg;
        cap = cap - 1;
        n = 0;
        while (n < cap) begin
          c = mem_at(probe + n);
          if (c == CH_NUL || c == CH_LF) break;
          n++;
          c = mem_at(probe + n);
          push_result(1, 1, mem_at(probe + n - 1),
                      (n == cap) || c == CH_NUL || c == CH_LF);
        end
        if (n == 0) push_result(1, 0, CH_NUL, 1);
        return;
      end
      if (want < id) hi = probe;
      else lo = line_after(probe);
    end
    push_result(0, 0, CH_NUL, 1);
  endfunction

  function automatic void apply_item(in_item_t it);
    case (it.mode)
      MODE_LOAD: begin
        if (shadow_wptr < STORE_BYTES) begin
          shadow_mem[shadow_wptr] = it.load_byte;
          shadow_wptr++;
        end
      end
      MODE_QUERY: begin
        queries_sent++;
        predict_lookup(longint'(it.search_id));
      end
      MODE_REWIND: shadow_wptr = 0;
      default: ;
    endcase
  endfunction

  // ---------------- driving ----------------
  task automatic send_item(logic [1:0] mode, logic [7:0] b, logic [23:0] id);
    in_item_t it;
    it.mode = mode;
    it.load_byte = b;
    it.search_id = id;
    if (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
    apply_item(it);
  endtask

  task automatic lookup(logic [23:0] id);
    send_item(MODE_QUERY, 8'($urandom), id);
  endtask

  // Let every owed result arrive, then let a trailing load settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (lookup_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_line_cap(logic [6:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    line_cap_reg = v;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) rec_bytes.push_back(s[i]);
  endtask

  // Rewind, then load "<region length>\n" followed by the record region.
  task automatic load_image();
    string hdr;
    hdr = $sformatf("%0d\n", rec_bytes.size());
    send_item(MODE_REWIND, 8'($urandom), 24'($urandom));
    for (int i = 0; i < hdr.len(); i++) send_item(MODE_LOAD, hdr[i], 24'($urandom));
    foreach (rec_bytes[i]) send_item(MODE_LOAD, rec_bytes[i], 24'($urandom));
    rec_bytes.delete();
  endtask

  task automatic load_header_only(string hdr);
    send_item(MODE_REWIND, 8'($urandom), 24'($urandom));
    for (int i = 0; i < hdr.len(); i++) send_item(MODE_LOAD, hdr[i], 24'($urandom));
  endtask

  // ---------------- tests ----------------
  task automatic test_directed_lookups();
    add_text("7,alpha\n");
    add_text(" +12,leading blank and plus\n");
    add_text("20,nul");
    rec_bytes.push_back(CH_NUL);
    add_text("after\n");
    add_text("35,");
    for (int i = 0; i < 66; i++) rec_bytes.push_back(8'(8'h41 + i % 26));
    rec_bytes.push_back(CH_LF);
    add_text("99999999999,saturated\n");
    load_image();
    lookup(24'd7);
    lookup(24'd12);
    lookup(24'd20);
    lookup(24'd35);      // truncated at the line cap
    lookup(24'd0);       // below every record
    lookup(24'hFFFFFF);  // above every record but the saturated one
    lookup(24'd8);
    send_item(2'd3, 8'hFF, 24'hFFFFFF);  // unused mode, ignored
  endtask

  task automatic test_line_cap();
    set_line_cap(7'd1);    // found with no characters
    lookup(24'd7);
    set_line_cap(7'd0);    // treated as one
    lookup(24'd35);
    set_line_cap(7'd127);  // clamps to 64
    lookup(24'd35);
    set_line_cap(7'd3);
    lookup(24'd12);
    set_line_cap(7'd64);
    lookup(24'd35);
  endtask

  task automatic test_rejected_headers();
    load_header_only("0\n");
    lookup(24'd0);
    load_header_only("-5\n");
    lookup(24'd5);
    load_header_only("9340032\n");
    lookup(24'd1);
    load_header_only("70000\n");  // region would run past the store end
    lookup(24'd1);
  endtask

  // Sorted images with random content; most lookups hit a stored ID.
  task automatic test_random_images();
    int ids[$];
    int nrec, id, pick;
    string pre;
    for (int img = 0; img < 3; img++) begin
      if (img == 1) set_line_cap(7'($urandom_range(1, 20)));
      if (img == 2) set_line_cap(7'd64);
      calm = (img == 2);
      ids.delete();
      nrec = $urandom_range(1, 5);
      id = $urandom_range(0, 50);
      for (int r = 0; r < nrec; r++) begin
        ids.push_back(id);
        case ($urandom_range(4))
          0: pre = " ";
          1: pre = "+";
          2: pre = "\t0";
          default: pre = "";
        endcase
        add_text($sformatf("%s%0d,", pre, id));
        for (int k = $urandom_range(0, 6); k > 0; k--)
          rec_bytes.push_back(8'($urandom_range(32, 126)));
        if ($urandom_range(9) == 0) rec_bytes.push_back(CH_NUL);
        rec_bytes.push_back(CH_LF);
        id += (r == nrec - 2 && $urandom_range(1)) ? $urandom_range(1, 16777215 - id)
                                                   : $urandom_range(1, 3000);
        if (id > 16777215) break;
      end
      load_image();
      for (int q = 0; q < 10; q++) begin
        pick = $urandom_range(9);
        if (pick < 6) lookup(24'(ids[$urandom_range(ids.size() - 1)]));
        else if (pick < 8) lookup(24'(ids[$urandom_range(ids.size() - 1)] + 1));
        else lookup(24'($urandom));
        if ($urandom_range(49) == 0) send_item(MODE_LOAD, 8'($urandom), 24'($urandom));
      end
      // hold the sender until every result is back at least once per image
      drain();
    end
    calm = 1'b0;
  endtask

  // ---------------- checking ----------------
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (lookup_q.size() == 0) begin
        report("unexpected item", out_data, '0);
      end else begin
        if (out_data !== lookup_q[0]) report("field", out_data, lookup_q[0]);
        if (lookup_q[0].found && lookup_q[0].last) hits_seen++;
        void'(lookup_q.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(99) >= 14);
  end

  // Watchdog: cycles with no item accepted on either side.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout with %0d results outstanding", lookup_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < STORE_BYTES; i++) shadow_mem[i] = CH_NUL;
    shadow_wptr = 0;
    line_cap_reg = 64;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_lookups();
    test_line_cap();
    test_rejected_headers();
    test_random_images();
    drain();
    repeat (20) @(posedge clk);
    $display("Covered %0d lookups (%0d hits) and %0d result items: directed records,",
             queries_sent, hits_seen, results_seen);
    $display("rejected headers, line cap extremes and random sorted images.");
    if (errors == 0 && lookup_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/stlbs_pkg.sv
rtl/stlbs_store.sv
rtl/stlbs_ctrl.sv
rtl/sorted_text_line_binary_search.sv
sim/sorted_text_line_binary_search_tb.sv
